// ----- rtl/adcd_pkg.sv -----
// Shared types and constants for the diffusion decay model evaluator.
`timescale 1ns / 1ps

package adcd_pkg;

	// Q31 fixed-point unity and one half.
	localparam logic [31:0] Q31_ONE  = 32'h8000_0000;
	localparam logic [31:0] Q31_HALF = 32'h4000_0000;

	// Products b*adc at or above this value decay to zero.
	localparam logic [25:0] DECAY_CUTOFF = 26'd12000000;

	// Scaling of b*adc to x/16 in Q31: t = floor((P * 2^21 + T_ROUND) / T_DIVISOR).
	localparam int          T_DIVISOR = 15625;
	localparam logic [12:0] T_ROUND   = 13'd7812;

	// Taylor terms of the Horner evaluation and the number of squarings.
	localparam int TAYLOR_TERMS = 12;
	localparam int SQUARINGS    = 4;

	// Per-request fields that ride along the pipeline.
	typedef struct packed {
		logic [15:0] s0;
		logic [13:0] b_value;
		logic [15:0] measured;
		logic        zero;
	} side_t;

	// Side fields plus the reduced argument used by every Horner step.
	typedef struct packed {
		side_t       side;
		logic [30:0] t;
	} hside_t;

endpackage

// ----- rtl/adcd_cdiv.sv -----
// Two-stage division of an unsigned value by a constant, by reciprocal and correction.
`timescale 1ns / 1ps

module adcd_cdiv #(
	parameter int WIDTH   = 31,
	parameter int DIVISOR = 3,
	parameter int SIDE_W  = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [WIDTH-1:0]  num,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_valid,
	output logic [WIDTH-1:0]  quot,
	output logic [WIDTH-1:0]  rem,
	output logic [SIDE_W-1:0] side_out
);

	// floor((2^WIDTH - 1) / DIVISOR) underestimates the quotient by at most one.
	localparam logic [WIDTH-1:0] RECIP =
		WIDTH'(((64'd1 << WIDTH) - 64'd1) / 64'(DIVISOR));
	localparam logic [WIDTH-1:0] DIV_C = WIDTH'(DIVISOR);

	logic                 valid_s1;
	logic [2*WIDTH-1:0]   prod_s1;
	logic [WIDTH-1:0]     num_s1;
	logic [SIDE_W-1:0]    side_s1;
	logic                 valid_s2;
	logic [WIDTH-1:0]     quot_s2;
	logic [WIDTH-1:0]     rem_s2;
	logic [SIDE_W-1:0]    side_s2;

	logic [WIDTH-1:0]     q_est;
	logic [WIDTH-1:0]     r_est;
	logic                 fix;

	// Valid bits of both stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	// Stage one: multiply by the reciprocal.
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= (2*WIDTH)'(num) * (2*WIDTH)'(RECIP);
			num_s1  <= num;
			side_s1 <= side_in;
		end
	end

	// The estimate is the exact quotient or one less; the remainder tells which.
	always_comb begin
		q_est = prod_s1[2*WIDTH-1:WIDTH];
		r_est = num_s1 - q_est * DIV_C;
		fix   = (r_est >= DIV_C);
	end

	// Stage two: corrected quotient and remainder.
	always_ff @(posedge clk) begin
		if (en) begin
			quot_s2 <= fix ? q_est + WIDTH'(1) : q_est;
			rem_s2  <= fix ? r_est - DIV_C : r_est;
			side_s2 <= side_s1;
		end
	end

	assign out_valid = valid_s2;
	assign quot      = quot_s2;
	assign rem       = rem_s2;
	assign side_out  = side_s2;

endmodule

// ----- rtl/adcd_hstep.sv -----
// One Horner step of the exp(-t) Taylor series: r = 1 - round(t * r / TERM) in Q31.
`timescale 1ns / 1ps

module adcd_hstep import adcd_pkg::*; #(
	parameter int TERM = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  logic [31:0] r_in,
	input  hside_t      hs_in,
	output logic        out_valid,
	output logic [31:0] r_out,
	output hside_t      hs_out
);

	// Rounding offset TERM * 2^30 ahead of the shift by 31.
	localparam logic [62:0] ROUND_C = 63'(TERM) << 30;

	logic        valid_s1;
	logic [62:0] prod_s1;
	hside_t      hs_s1;
	logic        valid_s2;
	logic [30:0] y_s2;
	hside_t      hs_s2;
	logic        div_valid;
	logic [30:0] div_quot;
	hside_t      div_side;
	logic        valid_s5;
	logic [31:0] r_s5;
	hside_t      hs_s5;
	logic [62:0] sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s5 <= div_valid;
		end
	end

	// Stage one: t times r.
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= 63'(hs_in.t) * 63'(r_in);
			hs_s1   <= hs_in;
		end
	end

	// Stage two: scale back to Q31 with the rounding offset.
	assign sum = prod_s1 + ROUND_C;

	always_ff @(posedge clk) begin
		if (en) begin
			y_s2  <= sum[61:31];
			hs_s2 <= hs_s1;
		end
	end

	// Stages three and four: divide by the term index.
	adcd_cdiv #(
		.WIDTH   (31),
		.DIVISOR (TERM),
		.SIDE_W  ($bits(hside_t))
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_s2),
		.num       (y_s2),
		.side_in   (hs_s2),
		.out_valid (div_valid),
		.quot      (div_quot),
		.rem       (),
		.side_out  (div_side)
	);

	// Stage five: subtract from one. The quotient always stays below one.
	always_ff @(posedge clk) begin
		if (en) begin
			r_s5  <= Q31_ONE - {1'b0, div_quot};
			hs_s5 <= div_side;
		end
	end

	assign out_valid = valid_s5;
	assign r_out     = r_s5;
	assign hs_out    = hs_s5;

endmodule

// ----- rtl/adcd_square.sv -----
// One rounded Q31 squaring step, two pipeline stages.
`timescale 1ns / 1ps

module adcd_square import adcd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  logic [31:0] r_in,
	input  side_t       side_in,
	output logic        out_valid,
	output logic [31:0] r_out,
	output side_t       side_out
);

	logic        valid_s1;
	logic [63:0] prod_s1;
	side_t       side_s1;
	logic        valid_s2;
	logic [31:0] r_s2;
	side_t       side_s2;
	logic [63:0] sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	// Stage one: r squared.
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= 64'(r_in) * 64'(r_in);
			side_s1 <= side_in;
		end
	end

	// Stage two: round to Q31. With r at most one the result is at most one.
	assign sum = prod_s1 + 64'(Q31_HALF);

	always_ff @(posedge clk) begin
		if (en) begin
			r_s2    <= sum[62:31];
			side_s2 <= side_s1;
		end
	end

	assign out_valid = valid_s2;
	assign r_out     = r_s2;
	assign side_out  = side_s2;

endmodule

// ----- rtl/adc_decay_model_eval.sv -----
// Top level of the diffusion decay model evaluator: S0*exp(-b*ADC), residual and Jacobian.
// Throughput: one request per cycle; 12 Horner steps of 5 stages and 4 squarings of 2 stages
// make up most of the depth. The whole pipeline holds while a result waits on the output.
// Reset: arst_n clears all valid bits and sets subtract_measured to 0; data registers
// are not reset.
`timescale 1ns / 1ps

module adc_decay_model_eval import adcd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [15:0]        s0,
	input  logic [11:0]        adc,
	input  logic [13:0]        b_value,
	input  logic [15:0]        measured,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [16:0] model_value,
	output logic [16:0]        deriv_s0,
	output logic signed [30:0] deriv_adc
);

	// Side fields during the argument reduction.
	typedef struct packed {
		side_t       side;
		logic [9:0]  qp;
	} fside_t;

	typedef struct packed {
		side_t       side;
		logic [9:0]  qp;
		logic [7:0]  q1;
	} tside_t;

	logic               subtract_measured_q;
	logic               en;

	logic               valid_s1;
	logic [25:0]        p_s1;
	side_t              side_s1;
	side_t              side_z;

	logic               d0_valid;
	logic [25:0]        d0_quot;
	logic [25:0]        d0_rem;
	side_t              d0_side;
	fside_t             d1_side_in;
	logic               d1_valid;
	logic [21:0]        d1_quot;
	logic [21:0]        d1_rem;
	fside_t             d1_side;
	tside_t             d2_side_in;
	logic               d2_valid;
	logic [26:0]        d2_quot;
	tside_t             d2_side;

	logic               valid_s8;
	hside_t             hs_s8;

	logic               hv [0:TAYLOR_TERMS];
	logic [31:0]        hr [0:TAYLOR_TERMS];
	hside_t             hs [0:TAYLOR_TERMS];
	logic               sv [0:SQUARINGS];
	logic [31:0]        sr [0:SQUARINGS];
	side_t              ss [0:SQUARINGS];

	logic               valid_s77;
	logic [47:0]        mprod_s77;
	logic [16:0]        deriv_s0_s77;
	side_t              side_s77;
	logic [31:0]        e_final;
	logic [47:0]        msum;

	logic               valid_s78;
	logic [15:0]        model_s78;
	logic [16:0]        deriv_s0_s78;
	side_t              side_s78;

	logic               valid_s79;
	logic [29:0]        bm_s79;
	logic [16:0]        value_s79;
	logic [16:0]        deriv_s0_s79;

	logic               valid_s80;
	logic [16:0]        value_s80;
	logic [16:0]        deriv_s0_s80;
	logic [30:0]        deriv_adc_s80;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			subtract_measured_q <= 1'b0;
		end else if (cfg_we) begin
			subtract_measured_q <= cfg_wdata;
		end
	end

	// The whole pipeline advances unless a result waits on the output register.
	assign en       = !valid_s80 || out_ready;
	assign in_ready = en;

	// Valid bits of the stages owned by the top level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s8  <= 1'b0;
			valid_s77 <= 1'b0;
			valid_s78 <= 1'b0;
			valid_s79 <= 1'b0;
			valid_s80 <= 1'b0;
		end else if (en) begin
			valid_s1  <= in_valid;
			valid_s8  <= d2_valid;
			valid_s77 <= sv[SQUARINGS];
			valid_s78 <= valid_s77;
			valid_s79 <= valid_s78;
			valid_s80 <= valid_s79;
		end
	end

	// Stage one: the product b*adc.
	always_ff @(posedge clk) begin
		if (en) begin
			p_s1    <= 26'(b_value) * 26'(adc);
			side_s1 <= '{s0: s0, b_value: b_value, measured: measured, zero: 1'b0};
		end
	end

	// Strong decay is flagged here and forces the decay term to zero at the end.
	always_comb begin
		side_z      = side_s1;
		side_z.zero = (p_s1 >= DECAY_CUTOFF);
	end

	// Split P into quotient and remainder by 15625.
	adcd_cdiv #(
		.WIDTH   (26),
		.DIVISOR (T_DIVISOR),
		.SIDE_W  ($bits(side_t))
	) u_div0 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_s1),
		.num       (p_s1),
		.side_in   (side_z),
		.out_valid (d0_valid),
		.quot      (d0_quot),
		.rem       (d0_rem),
		.side_out  (d0_side)
	);

	// Long division of remainder * 2^21 + 7812: first an 8-bit digit.
	assign d1_side_in = '{side: d0_side, qp: d0_quot[9:0]};

	adcd_cdiv #(
		.WIDTH   (22),
		.DIVISOR (T_DIVISOR),
		.SIDE_W  ($bits(fside_t))
	) u_div1 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (d0_valid),
		.num       ({d0_rem[13:0], 8'd0}),
		.side_in   (d1_side_in),
		.out_valid (d1_valid),
		.quot      (d1_quot),
		.rem       (d1_rem),
		.side_out  (d1_side)
	);

	// Then a 13-bit digit, which also takes the rounding offset.
	assign d2_side_in = '{side: d1_side.side, qp: d1_side.qp, q1: d1_quot[7:0]};

	adcd_cdiv #(
		.WIDTH   (27),
		.DIVISOR (T_DIVISOR),
		.SIDE_W  ($bits(tside_t))
	) u_div2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (d1_valid),
		.num       ({d1_rem[13:0], T_ROUND}),
		.side_in   (d2_side_in),
		.out_valid (d2_valid),
		.quot      (d2_quot),
		.rem       (),
		.side_out  (d2_side)
	);

	// Stage eight: assemble the reduced argument t = x/16 in Q31.
	always_ff @(posedge clk) begin
		if (en) begin
			hs_s8.side <= d2_side.side;
			hs_s8.t    <= d2_side.side.zero ? 31'd0 : {d2_side.qp, d2_side.q1, d2_quot[12:0]};
		end
	end

	assign hv[0] = valid_s8;
	assign hr[0] = Q31_ONE;
	assign hs[0] = hs_s8;

	// Horner chain from the highest term down to the first.
	for (genvar i = 0; i < TAYLOR_TERMS; i++) begin : g_horner
		adcd_hstep #(
			.TERM (TAYLOR_TERMS - i)
		) u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (hv[i]),
			.r_in      (hr[i]),
			.hs_in     (hs[i]),
			.out_valid (hv[i+1]),
			.r_out     (hr[i+1]),
			.hs_out    (hs[i+1])
		);
	end

	assign sv[0] = hv[TAYLOR_TERMS];
	assign sr[0] = hr[TAYLOR_TERMS];
	assign ss[0] = hs[TAYLOR_TERMS].side;

	// Repeated squaring undoes the division of x by 16.
	for (genvar k = 0; k < SQUARINGS; k++) begin : g_square
		adcd_square u_sq (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (sv[k]),
			.r_in      (sr[k]),
			.side_in   (ss[k]),
			.out_valid (sv[k+1]),
			.r_out     (sr[k+1]),
			.side_out  (ss[k+1])
		);
	end

	// Stage 77: final decay term, its Q1.16 form and S0 times it.
	assign e_final = ss[SQUARINGS].zero ? 32'd0 : sr[SQUARINGS];

	always_ff @(posedge clk) begin
		if (en) begin
			mprod_s77    <= 48'(ss[SQUARINGS].s0) * 48'(e_final);
			deriv_s0_s77 <= 17'((33'(e_final) + 33'h4000) >> 15);
			side_s77     <= ss[SQUARINGS];
		end
	end

	// Stage 78: round the model value back to an integer.
	assign msum = mprod_s77 + 48'(Q31_HALF);

	always_ff @(posedge clk) begin
		if (en) begin
			model_s78    <= msum[46:31];
			deriv_s0_s78 <= deriv_s0_s77;
			side_s78     <= side_s77;
		end
	end

	// Stage 79: b times the model value and the optional residual.
	always_ff @(posedge clk) begin
		if (en) begin
			bm_s79       <= 30'(side_s78.b_value) * 30'(model_s78);
			value_s79    <= subtract_measured_q ?
				{1'b0, model_s78} - {1'b0, side_s78.measured} : {1'b0, model_s78};
			deriv_s0_s79 <= deriv_s0_s78;
		end
	end

	// Stage 80: output register with the negated ADC derivative.
	always_ff @(posedge clk) begin
		if (en) begin
			deriv_adc_s80 <= 31'd0 - {1'b0, bm_s79};
			value_s80     <= value_s79;
			deriv_s0_s80  <= deriv_s0_s79;
		end
	end

	assign out_valid   = valid_s80;
	assign model_value = $signed(value_s80);
	assign deriv_s0    = deriv_s0_s80;
	assign deriv_adc   = $signed(deriv_adc_s80);

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the diffusion decay model evaluator, with its own decay predictor.
`timescale 1ns / 1ps

module tb_top;

	// Fixed-point constants of the decay predictor.
	localparam logic [63:0] Q31_UNITY    = 64'h8000_0000;
	localparam logic [63:0] Q31_HALFWAY  = 64'h4000_0000;
	localparam logic [63:0] DECAY_LIMIT  = 64'd12000000;
	localparam int          HORNER_TERMS = 12;
	localparam int          SQUARE_PASSES = 4;
	localparam int          STALL_LIMIT  = 4000;
	localparam int          DRAIN_CYCLES = 100;
	localparam int          RANDOM_PHASES = 4;
	localparam int          PHASE_SAMPLES = 125;

	typedef struct {
		logic [15:0] s0;
		logic [11:0] adc;
		logic [13:0] b;
		logic [15:0] meas;
	} decay_sample_t;

	typedef struct {
		logic signed [16:0] model_value;
		logic [16:0]        deriv_s0;
		logic signed [30:0] deriv_adc;
	} decay_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic               cfg_wdata = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [15:0]        s0 = '0;
	logic [11:0]        adc = '0;
	logic [13:0]        b_value = '0;
	logic [15:0]        measured = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [16:0] model_value;
	logic [16:0]        deriv_s0;
	logic signed [30:0] deriv_adc;

	decay_sample_t pending_samples[$];
	decay_result_t expected_results[$];
	decay_sample_t cur_sample;
	decay_result_t oldest_result;
	logic          resid_mode;
	logic          calm = 1'b0;
	int            errors = 0;
	int            n_samples = 0;
	int            n_resid = 0;
	int            n_cutoff = 0;
	int            n_results = 0;
	int            stall_cycles = 0;

	adc_decay_model_eval i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.s0         (s0),
		.adc        (adc),
		.b_value    (b_value),
		.measured   (measured),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.model_value(model_value),
		.deriv_s0   (deriv_s0),
		.deriv_adc  (deriv_adc)
	);

	always #2 clk = ~clk;

	// Decay term by range reduction, a Horner pass over the Taylor series and four squarings.
	function automatic decay_result_t predict_decay(decay_sample_t smp, logic mode);
		logic [63:0] prod;
		logic [63:0] t;
		logic [63:0] r;
		logic [63:0] q;
		logic [63:0] e;
		logic [63:0] model;
		decay_result_t res;
		prod = 64'(smp.b) * 64'(smp.adc);
		if (prod >= DECAY_LIMIT) begin
			e = '0;
		end else begin
			t = ((prod << 27) + 64'd500000) / 64'd1000000;
			r = Q31_UNITY;
			for (int n = HORNER_TERMS; n >= 1; n--) begin
				q = (t * r + 64'(n) * Q31_HALFWAY) / (64'(n) * Q31_UNITY);
				r = (q > Q31_UNITY) ? 64'd0 : Q31_UNITY - q;
			end
			for (int k = 0; k < SQUARE_PASSES; k++)
				r = (r * r + Q31_HALFWAY) >> 31;
			e = r;
		end
		model = (64'(smp.s0) * e + Q31_HALFWAY) >> 31;
		res.model_value = mode ? model[16:0] - {1'b0, smp.meas} : model[16:0];
		res.deriv_s0 = 17'((e + 64'h4000) >> 15);
		res.deriv_adc = 31'(64'd0 - 64'(smp.b) * model);
		return res;
	endfunction

	// Random sample: mostly moderate decay, some around the cutoff, the rest anywhere.
	function automatic decay_sample_t random_sample();
		int unsigned kind;
		int unsigned lim;
		decay_sample_t smp;
		kind = $urandom_range(99);
		if (kind < 55) begin
			smp.b = 14'($urandom_range(16383));
			lim = (smp.b == 0) ? 4095 : 11999999 / smp.b;
			smp.adc = 12'($urandom_range((lim > 4095) ? 4095 : lim));
		end else if (kind < 70) begin
			smp.b = 14'($urandom_range(16383, 2931));
			lim = 12000000 / smp.b - 1 + $urandom_range(2);
			smp.adc = 12'((lim > 4095) ? 4095 : lim);
		end else begin
			smp.b = 14'($urandom_range(16383));
			smp.adc = 12'($urandom_range(4095));
		end
		case ($urandom_range(9))
			0: smp.s0 = 16'hFFFF;
			1: smp.s0 = '0;
			default: smp.s0 = 16'($urandom_range(65535));
		endcase
		case ($urandom_range(9))
			0: smp.meas = 16'hFFFF;
			1: smp.meas = '0;
			2: smp.meas = smp.s0;
			default: smp.meas = 16'($urandom_range(65535));
		endcase
		return smp;
	endfunction

	task automatic push_sample(int a, int c, int b, int m);
		decay_sample_t smp;
		smp.s0 = 16'(a);
		smp.adc = 12'(c);
		smp.b = 14'(b);
		smp.meas = 16'(m);
		pending_samples.push_back(smp);
	endtask

	// Field extremes, both sides of the strong-decay cutoff and b-values up to the field maximum.
	task automatic push_directed();
		push_sample(0, 0, 0, 0);
		push_sample(65535, 0, 0, 65535);
		push_sample(65535, 4095, 16383, 65535);
		push_sample(65535, 1199, 10000, 0);
		push_sample(65535, 1200, 10000, 65535);
		push_sample(65535, 4095, 2930, 100);
		push_sample(40000, 4000, 3000, 12345);
		push_sample(65535, 1, 1, 1);
		push_sample(1, 4095, 1, 0);
		push_sample(65535, 2048, 1000, 65535);
		push_sample(0, 4095, 16383, 65535);
		push_sample(12345, 3000, 0, 54321);
	endtask

	// Writes the mode register while the block is idle.
	task automatic set_mode(logic m);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_samples.size() != 0 || in_valid || expected_results.size() != 0);
	endtask

	// Mirror of the mode register.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			resid_mode <= 1'b0;
		else if (cfg_we)
			resid_mode <= cfg_wdata;
	end

	// Request driver: predicts on acceptance, then presents the next pending sample.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				expected_results.push_back(predict_decay(cur_sample, resid_mode));
				n_samples++;
				if (resid_mode)
					n_resid++;
				if (64'(cur_sample.b) * 64'(cur_sample.adc) >= DECAY_LIMIT)
					n_cutoff++;
			end
			if (!in_valid || in_ready) begin
				if (pending_samples.size() != 0 && (calm || $urandom_range(99) >= 18)) begin
					cur_sample = pending_samples.pop_front();
					in_valid <= 1'b1;
					s0 <= cur_sample.s0;
					adc <= cur_sample.adc;
					b_value <= cur_sample.b;
					measured <= cur_sample.meas;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: compares each accepted result with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				n_results++;
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result model_value=%0d deriv_s0=%0d deriv_adc=%0d",
						$time, model_value, deriv_s0, deriv_adc);
					errors++;
				end else begin
					oldest_result = expected_results.pop_front();
					if (model_value !== oldest_result.model_value) begin
						$display("%0t: model_value expected %0d actual %0d",
							$time, oldest_result.model_value, model_value);
						errors++;
					end
					if (deriv_s0 !== oldest_result.deriv_s0) begin
						$display("%0t: deriv_s0 expected %0d actual %0d",
							$time, oldest_result.deriv_s0, deriv_s0);
						errors++;
					end
					if (deriv_adc !== oldest_result.deriv_adc) begin
						$display("%0t: deriv_adc expected %0d actual %0d",
							$time, oldest_result.deriv_adc, deriv_adc);
						errors++;
					end
				end
			end
			out_ready <= calm || ($urandom_range(99) >= 18);
		end
	end

	// Watchdog on cycles without any handshake while work is outstanding.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) ||
			(pending_samples.size() == 0 && !in_valid && expected_results.size() == 0))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
			$display("adc_decay_model_eval: mismatch");
			$finish;
		end
	end

	// Test sequence: directed samples in both modes, then random phases with alternating mode.
	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		set_mode(1'b0);
		push_directed();
		wait_drained();
		set_mode(1'b1);
		push_directed();
		wait_drained();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			set_mode(ph[0]);
			calm <= (ph == 2);
			for (int i = 0; i < PHASE_SAMPLES; i++)
				pending_samples.push_back(random_sample());
			wait_drained();
		end
		calm <= 1'b0;

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Checked %0d results from %0d samples,", n_results, n_samples);
		$display("%0d in residual mode and %0d past the cutoff.", n_resid, n_cutoff);
		if (errors == 0)
			$display("adc_decay_model_eval: match");
		else
			$display("adc_decay_model_eval: mismatch");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/adcd_pkg.sv
rtl/adcd_cdiv.sv
rtl/adcd_hstep.sv
rtl/adcd_square.sv
rtl/adc_decay_model_eval.sv
tb/tb_top.sv
